/* rtl/pstf_pkg.sv */
// ----------------------------------------------------------------------------
// pstf_pkg
// Shared types, register codes and helpers of the PCM sample to float block.
// ----------------------------------------------------------------------------
package pstf_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MantW  = 24;
  localparam int unsigned ProdW  = 2 * MantW;
  localparam int unsigned ExpW   = 11;

  localparam logic [1:0] RegSampleBytes = 2'd0;
  localparam logic [1:0] RegBigEndian   = 2'd1;
  localparam logic [1:0] RegFloatMode   = 2'd2;
  localparam logic [1:0] RegGainBits    = 2'd3;

  localparam logic [2:0]       SampleBytesRst = 3'd2;
  localparam logic [WordW-1:0] GainBitsRst    = 32'h3000_0000;
  localparam logic [WordW-1:0] QNanBits       = 32'h7FC0_0000;

  // product handed to the round stage
  typedef struct packed {
    logic                   sign;
    logic                   nan;
    logic                   inf;
    logic                   zero;
    logic signed [ExpW-1:0] exp;
    logic [ProdW-1:0]       prod;
  } prod_t;

  // leading zero count, 32 for an all-zero word
  function automatic logic [5:0] lzc32(input logic [WordW-1:0] v);
    logic [5:0] cnt;
    cnt = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        cnt = 6'(31 - i);
      end
    end
    return cnt;
  endfunction

endpackage

/* rtl/pstf_round.sv */
// ----------------------------------------------------------------------------
// pstf_round
// Normalizes and rounds a 48-bit significand product to single precision.
// ----------------------------------------------------------------------------
module pstf_round
  import pstf_pkg::*;
(
  input  prod_t             prod_i,
  output logic [WordW-1:0]  bits_o
);

  logic                   top;
  logic [ProdW-1:0]       pn;
  logic signed [ExpW-1:0] e;
  logic signed [ExpW-1:0] sh_s;
  logic [5:0]             sh;
  logic [ProdW-1:0]       den;
  logic [ProdW-1:0]       mask;
  logic                   lost;
  logic [30:0]            field;
  logic                   grd;
  logic                   stk;
  logic [30:0]            rnd;

  always_comb begin
    top  = prod_i.prod[ProdW-1];
    pn   = top ? prod_i.prod : (prod_i.prod << 1);
    e    = prod_i.exp - (top ? ExpW'(0) : ExpW'(1));
    sh_s = ExpW'(1) - e;
    sh   = (sh_s > $signed(ExpW'(49))) ? 6'd49 : sh_s[5:0];
    mask = ProdW'((49'(1) << sh) - 49'(1));
    den  = pn >> sh;
    lost = |(pn & mask);
    if (e > $signed(ExpW'(0))) begin
      field = {e[7:0], pn[46:24]};
      grd   = pn[23];
      stk   = |pn[22:0];
    end else begin
      field = {8'd0, den[46:24]};
      grd   = den[23];
      stk   = (|den[22:0]) | lost;
    end
    // carry out of the fraction bumps the exponent, up to infinity
    rnd = field + 31'(grd & (stk | field[0]));
    if (prod_i.nan) begin
      bits_o = QNanBits;
    end else if (prod_i.inf) begin
      bits_o = {prod_i.sign, 8'hFF, 23'd0};
    end else if (prod_i.zero) begin
      bits_o = {prod_i.sign, 31'd0};
    end else if (e > $signed(ExpW'(254))) begin
      bits_o = {prod_i.sign, 8'hFF, 23'd0};
    end else begin
      bits_o = {prod_i.sign, rnd};
    end
  end

endmodule

/* rtl/pcm_sample_to_float.sv */
// ----------------------------------------------------------------------------
// pcm_sample_to_float
// Packed PCM sample bytes to IEEE single precision, with gain.
// ----------------------------------------------------------------------------
// Four-stage pipeline: byte assembly, integer to float with gain unpacking,
// 24x24 significand multiply, then normalize and round to nearest even. One
// sample is taken every cycle while the output register is empty or being taken.
// The whole pipeline advances together whenever the output register is empty
// or being taken. Configuration is written with a valid/ready handshake whose
// ready is tied high, and must only change while the pipeline is empty.
module pcm_sample_to_float
  import pstf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [WordW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] raw_bytes_i,
  input  logic             last_sample_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] sample_value_o,
  output logic             last_out_o
);

  logic [2:0]       sample_bytes_q;
  logic             big_endian_q;
  logic             float_mode_q;
  logic [WordW-1:0] gain_bits_q;

  logic en;

  // stage a
  logic             a_valid_q;
  logic [WordW-1:0] a_bits_q, a_bits_d;
  logic             a_last_q;
  // stage b
  logic             b_valid_q;
  logic [WordW-1:0] b_bits_q;
  logic             b_last_q;
  logic             b_xsign_q, b_xzero_q;
  logic [7:0]       b_xexp_q, b_xexp_d;
  logic [22:0]      b_xfrac_q, b_xfrac_d;
  logic             b_gsign_q, b_gnan_q, b_ginf_q, b_gzero_q;
  logic [MantW-1:0] b_gmant_q, b_gmant_d;
  logic signed [9:0] b_gexp_q, b_gexp_d;
  // stage c
  logic             c_valid_q;
  logic [WordW-1:0] c_bits_q;
  logic             c_last_q;
  prod_t            c_prod_q, c_prod_d;
  // output
  logic             out_valid_q;
  logic [WordW-1:0] out_bits_q;
  logic             out_last_q;
  logic [WordW-1:0] rnd_bits;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bytes_q <= SampleBytesRst;
      big_endian_q   <= 1'b0;
      float_mode_q   <= 1'b0;
      gain_bits_q    <= GainBitsRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSampleBytes: sample_bytes_q <= cfg_data_i[2:0];
        RegBigEndian:   big_endian_q   <= cfg_data_i[0];
        RegFloatMode:   float_mode_q   <= cfg_data_i[0];
        RegGainBits:    gain_bits_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte assembly, left aligned
  logic [2:0]       nb;
  logic [WordW-1:0] rev;
  always_comb begin
    nb = sample_bytes_q;
    if (nb == 3'd0) nb = 3'd1;
    if (nb > 3'd4) nb = 3'd4;
    rev = {raw_bytes_i[7:0], raw_bytes_i[15:8], raw_bytes_i[23:16], raw_bytes_i[31:24]};
    if (big_endian_q) begin
      a_bits_d = rev & ~(WordW'(32'hFFFF_FFFF) >> (6'(nb) * 6'(ByteW)));
    end else begin
      a_bits_d = raw_bytes_i << (6'd32 - 6'(nb) * 6'(ByteW));
    end
  end

  // integer to float, gain unpacking
  logic             xs;
  logic [WordW-1:0] mag, norm;
  logic [5:0]       lz, lzg;
  logic [30:0]      xf;
  logic [7:0]       gexp;
  logic [22:0]      gfrac;
  always_comb begin
    xs        = a_bits_q[WordW-1];
    mag       = xs ? (~a_bits_q + WordW'(1)) : a_bits_q;
    lz        = lzc32(mag);
    norm      = mag << lz[4:0];
    xf        = {8'(9'd158 - 9'(lz)), norm[30:8]};
    xf        = xf + 31'(norm[7] & ((|norm[6:0]) | norm[8]));
    b_xexp_d  = xf[30:23];
    b_xfrac_d = xf[22:0];
    gexp      = gain_bits_q[30:23];
    gfrac     = gain_bits_q[22:0];
    lzg       = lzc32({9'd0, gfrac}) - 6'd8;
    if (gexp == 8'd0) begin
      b_gmant_d = {1'b0, gfrac} << lzg[4:0];
      b_gexp_d  = 10'sd1 - 10'(lzg);
    end else begin
      b_gmant_d = {1'b1, gfrac};
      b_gexp_d  = 10'(gexp);
    end
  end

  // significand multiply
  always_comb begin
    c_prod_d.sign = b_xsign_q ^ b_gsign_q;
    c_prod_d.nan  = b_gnan_q || (b_ginf_q && b_xzero_q);
    c_prod_d.inf  = b_ginf_q && !b_xzero_q;
    c_prod_d.zero = b_xzero_q || b_gzero_q;
    c_prod_d.exp  = ExpW'(b_xexp_q) + ExpW'(b_gexp_q) - ExpW'(126);
    c_prod_d.prod = ProdW'({1'b1, b_xfrac_q}) * ProdW'(b_gmant_q);
  end

  pstf_round u_round (
    .prod_i (c_prod_q),
    .bits_o (rnd_bits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_bits_q   <= a_bits_d;
      a_last_q   <= last_sample_i;
      b_bits_q   <= a_bits_q;
      b_last_q   <= a_last_q;
      b_xsign_q  <= xs;
      b_xzero_q  <= (mag == '0);
      b_xexp_q   <= b_xexp_d;
      b_xfrac_q  <= b_xfrac_d;
      b_gsign_q  <= gain_bits_q[31];
      b_gnan_q   <= (gexp == 8'hFF) && (gfrac != '0);
      b_ginf_q   <= (gexp == 8'hFF) && (gfrac == '0);
      b_gzero_q  <= (gexp == 8'd0) && (gfrac == '0);
      b_gmant_q  <= b_gmant_d;
      b_gexp_q   <= b_gexp_d;
      c_bits_q   <= b_bits_q;
      c_last_q   <= b_last_q;
      c_prod_q   <= c_prod_d;
      out_bits_q <= float_mode_q ? c_bits_q : rnd_bits;
      out_last_q <= c_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_bits_q;
  assign last_out_o     = out_last_q;

`ifndef NO_ASSERTIONS
  // pipeline moves exactly when the output slot frees up
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  // integer mode only ever emits the canonical quiet nan
  a_qnan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !float_mode_q && (sample_value_o[30:23] == 8'hFF)
      && (sample_value_o[22:0] != 23'd0)) |-> (sample_value_o == QNanBits))
    else $error("non-canonical nan in integer mode");

  // a result held under stall keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_value_o)))
    else $error("stalled result changed");
`endif

endmodule

/* tb/sv/pcm_sample_to_float_test.sv */
// ----------------------------------------------------------------------------
// pcm_sample_to_float_test
// Self-checking bench for the PCM sample to float converter.
// ----------------------------------------------------------------------------
// Walks byte counts, byte orders, float mode and a range of gains, including
// NaN, infinite, denormal and zero gains. Every sample is predicted with an
// integer-only single-precision model and checked in order against the
// output stream, with random stalls on both sides.
`timescale 1ns / 1ps

module pcm_sample_to_float_test;
  import pstf_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] raw;
    logic             last;
  } sample_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             last;
  } conv_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = RegSampleBytes;
  logic [WordW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [WordW-1:0] raw_bytes_i = '0;
  logic             last_sample_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] sample_value_o;
  logic             last_out_o;

  pcm_sample_to_float i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // local copy of the registers
  logic [2:0]       nbytes_q;
  logic             big_endian_q;
  logic             float_mode_q;
  logic [WordW-1:0] gain_q;

  sample_t pending_samples[$];
  conv_t   expected_values[$];
  int      n_errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      send_hold = 1'b0;
  bit      in_fire = 1'b0;

  function automatic logic [WordW-1:0] align_bytes(logic [WordW-1:0] raw);
    int unsigned n;
    logic [WordW-1:0] acc;
    n = nbytes_q;
    acc = '0;
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    for (int k = 0; k < n; k++) begin
      acc = (acc << 8) | ((raw >> (8 * (big_endian_q ? k : n - 1 - k))) & 32'hFF);
    end
    return acc << (32 - 8 * n);
  endfunction

  // signed word to single precision, round to nearest even
  function automatic logic [WordW-1:0] int_to_single(logic [WordW-1:0] v);
    logic [WordW-1:0] mag;
    logic [WordW-1:0] m;
    int lz;
    longint keep;
    longint bits;
    mag = v[31] ? (~v + 1) : v;
    if (mag == 0) return '0;
    lz = 0;
    while (!mag[31 - lz]) lz++;
    m = mag << lz;
    keep = m[31:8];
    keep = keep + (m[7] & ((|m[6:0]) | m[8]));
    bits = (longint'(158 - lz) << 23) + keep - (1 << 23);
    return {v[31], bits[30:0]};
  endfunction

  function automatic logic [WordW-1:0] mul_single(logic [WordW-1:0] a, logic [WordW-1:0] b);
    logic s;
    int ea, eb, e, sh;
    longint ma, mb, p, keep, rem, mag;
    bit g, st;
    s = a[31] ^ b[31];
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
      return QNanBits;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:0] == 0 || b[30:0] == 0) return QNanBits;
      return {s, 8'hFF, 23'd0};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
    ea = a[30:23]; eb = b[30:23];
    ma = a[22:0]; mb = b[22:0];
    if (ea == 0) ea = 1; else ma = ma | (1 << 23);
    if (eb == 0) eb = 1; else mb = mb | (1 << 23);
    while (!ma[23]) begin ma = ma << 1; ea--; end
    while (!mb[23]) begin mb = mb << 1; eb--; end
    p = ma * mb;
    e = ea + eb - 127;
    if (p[47]) e++;
    else p = p << 1;
    sh = 24;
    if (e < 1) begin
      sh = sh + 1 - e;
      e = 0;
    end
    if (sh > 49) sh = 49;
    keep = p >> sh;
    rem = p & ((64'd1 << sh) - 1);
    g = rem[sh - 1];
    st = (rem & ((64'd1 << (sh - 1)) - 1)) != 0;
    keep = keep + (g & (st | keep[0]));
    if (e == 0) mag = keep;
    else mag = (longint'(e) << 23) + keep - (1 << 23);
    if (mag >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
    return {s, mag[30:0]};
  endfunction

  function automatic conv_t convert_sample(sample_t smp);
    conv_t r;
    logic [WordW-1:0] w;
    w = align_bytes(smp.raw);
    r.value = float_mode_q ? w : mul_single(int_to_single(w), gain_q);
    r.last = smp.last;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    $display("%0t: %s mismatch, got %08h want %08h", $realtime, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    conv_t want;
    in_fire = in_valid_i && in_ready_o;
    if (in_fire) expected_values.push_back(convert_sample({raw_bytes_i, last_sample_i}));
    if (out_valid_o && out_ready_i) begin
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected transfer", sample_value_o, '0);
      end else begin
        want = expected_values.pop_front();
        if (sample_value_o !== want.value)
          report_mismatch("sample_value", sample_value_o, want.value);
        if (last_out_o !== want.last) report_mismatch("last_out", last_out_o, want.last);
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    sample_t smp;
    if (!in_valid_i || in_fire) begin
      if (pending_samples.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
        smp = pending_samples.pop_front();
        in_valid_i <= 1'b1;
        raw_bytes_i <= smp.raw;
        last_sample_i <= smp.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= $urandom_range(99) >= recv_idle_pct;
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid_i || expected_values.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [WordW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegSampleBytes: nbytes_q = data[2:0];
      RegBigEndian:   big_endian_q = data[0];
      RegFloatMode:   float_mode_q = data[0];
      default:        gain_q = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] random_raw();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {$urandom_range(1) ? 8'h80 : 8'h7F, 8'h80, 8'h7F, 8'h80} ^ ($urandom & 32'h0101_0101);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_samples(int n);
    sample_t smp;
    for (int i = 0; i < n; i++) begin
      smp.raw = random_raw();
      smp.last = $urandom_range(1);
      pending_samples.push_back(smp);
    end
  endtask

  localparam int NumPhases = 14;
  logic [WordW-1:0] gain_set[NumPhases] = '{
    GainBitsRst, 32'h3F80_0000, 32'h7FC0_0001, 32'h7F80_0000, 32'h0000_0001,
    32'h8000_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'hBF80_0000, 32'h0080_0000,
    32'hFF80_0000, 32'h2F80_0000, 32'hFFFF_FFFF, 32'h5000_0000};
  logic [WordW-1:0] directed_raw[8] = '{
    32'h0, 32'hFFFF_FFFF, 32'h8080_8080, 32'h7F7F_7F7F,
    32'h0000_0001, 32'h0100_0000, 32'h1234_5678, 32'h8000_0000};

  initial begin
    sample_t smp;
    nbytes_q = SampleBytesRst;
    big_endian_q = 1'b0;
    float_mode_q = 1'b0;
    gain_q = GainBitsRst;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // reset settings first, directed extremes
    for (int i = 0; i < 8; i++) begin
      smp.raw = directed_raw[i];
      smp.last = i[0];
      pending_samples.push_back(smp);
    end
    wait_drained();
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < 5) begin
        send_idle_pct = 21; recv_idle_pct = 73;
      end else if (ph < 10) begin
        send_idle_pct = 73; recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_reg(RegSampleBytes, WordW'((ph < 8) ? ph : $urandom_range(1, 4)));
      write_reg(RegBigEndian, WordW'(ph % 2));
      write_reg(RegFloatMode, WordW'((ph % 4) == 3));
      write_reg(RegGainBits, gain_set[ph]);
      for (int i = 0; i < 8; i++) begin
        smp.raw = directed_raw[i];
        smp.last = ~i[0];
        pending_samples.push_back(smp);
      end
      queue_samples(50);
      if (ph == 6) begin
        // hold off until the pipeline is empty
        while (pending_samples.size() > 0) @(posedge clk_i);
        send_hold = 1'b1;
        while (in_valid_i || expected_values.size() > 0) @(posedge clk_i);
        send_hold = 1'b0;
      end
      queue_samples(55);
      wait_drained();
    end
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/pstf_pkg.sv
rtl/pstf_round.sv
rtl/pcm_sample_to_float.sv
tb/sv/pcm_sample_to_float_test.sv
